/* rtl/smpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared widths, codes and control structs for the stable min priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TAG_W         = 16;
   localparam int PRIO_W        = 16;
   localparam int FILL_W        = 5;
   localparam int STATUS_W      = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       load;
      logic       do_push;
      logic       do_pop;
      logic       write_rsp;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
   } stat_type;

endpackage

/* rtl/stable_min_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_unit
// Bounded priority queue, smallest priority first, ties in arrival order.
// ----------------------------------------------------------------------------
// Use: each req_ word is one operation, req_op 0 pushes req_task_tag with
// req_prio, req_op 1 pops the head (tag and priority ignored). Every word
// yields exactly one rsp_ word: the popped entry (zero unless a pop succeeded),
// a status (ok, pop on empty, push dropped on full), the head after the
// operation and the entry count.
// Sequence: the controller takes a word in its idle state, then executes it in
// its execute state once the output register is free, with a compare-and-shift
// across all slots that updates the whole array at once and writes the result.
// No new word is taken until the previous one has been executed.
// The result sits in an output register; a stalled receiver holds it there
// and the next word is still taken, but its operation waits until the
// register is free.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared, only the count.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_unit #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic        [smpq_pkg::TAG_W-1:0]    req_task_tag,
   input  logic signed [smpq_pkg::PRIO_W-1:0]   req_prio,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [smpq_pkg::TAG_W-1:0]    rsp_popped_task,
   output logic signed [smpq_pkg::PRIO_W-1:0]   rsp_popped_prio,
   output logic        [smpq_pkg::STATUS_W-1:0] rsp_status,
   output logic        [smpq_pkg::TAG_W-1:0]    rsp_head_task,
   output logic signed [smpq_pkg::PRIO_W-1:0]   rsp_head_prio,
   output logic                                 rsp_not_empty,
   output logic        [smpq_pkg::FILL_W-1:0]   rsp_fill
);

   smpq_pkg::cmd_type  cmd;
   smpq_pkg::stat_type stat;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_op),
      .req_task_tag    (req_task_tag),
      .req_prio        (req_prio),
      .rsp_popped_task (rsp_popped_task),
      .rsp_popped_prio (rsp_popped_prio),
      .rsp_status      (rsp_status),
      .rsp_head_task   (rsp_head_task),
      .rsp_head_prio   (rsp_head_prio),
      .rsp_not_empty   (rsp_not_empty),
      .rsp_fill        (rsp_fill)
   );

endmodule

/* rtl/smpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_ctrl
// Controller: takes one word, runs it through the datapath once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module smpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  smpq_pkg::stat_type stat,
   output smpq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.load      = 1'b0;
      cmd.do_push   = 1'b0;
      cmd.do_pop    = 1'b0;
      cmd.write_rsp = 1'b0;
      cmd.code      = smpq_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.write_rsp = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
               if (stat.is_pop) begin
                  if (stat.empty) cmd.code = smpq_pkg::ST_EMPTY;
                  else cmd.do_pop = 1'b1;
               end else begin
                  if (stat.full) cmd.code = smpq_pkg::ST_FULL;
                  else cmd.do_push = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/smpq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_datapath
// Sorted slot array with parallel compare and shift, occupancy count, input
// latch and result register.
// ----------------------------------------------------------------------------
module smpq_datapath #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smpq_pkg::cmd_type                   cmd,
   output smpq_pkg::stat_type                  stat,
   input  logic                                req_op,
   input  logic        [smpq_pkg::TAG_W-1:0]   req_task_tag,
   input  logic signed [smpq_pkg::PRIO_W-1:0]  req_prio,
   output logic        [smpq_pkg::TAG_W-1:0]   rsp_popped_task,
   output logic signed [smpq_pkg::PRIO_W-1:0]  rsp_popped_prio,
   output logic        [smpq_pkg::STATUS_W-1:0] rsp_status,
   output logic        [smpq_pkg::TAG_W-1:0]   rsp_head_task,
   output logic signed [smpq_pkg::PRIO_W-1:0]  rsp_head_prio,
   output logic                                rsp_not_empty,
   output logic        [smpq_pkg::FILL_W-1:0]  rsp_fill
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   logic                               in_op_ff;
   logic        [smpq_pkg::TAG_W-1:0]  in_tag_ff;
   logic signed [smpq_pkg::PRIO_W-1:0] in_prio_ff;

   logic        [smpq_pkg::TAG_W-1:0]  tag_ff  [DEPTH];
   logic signed [smpq_pkg::PRIO_W-1:0] prio_ff [DEPTH];
   logic        [smpq_pkg::TAG_W-1:0]  tag_in  [DEPTH];
   logic signed [smpq_pkg::PRIO_W-1:0] prio_in [DEPTH];
   logic [OCC_W-1:0]                   occ_ff, occ_in;

   logic [DEPTH-1:0] keep;

   logic        [smpq_pkg::TAG_W-1:0]    popped_task_ff, head_task_ff;
   logic signed [smpq_pkg::PRIO_W-1:0]   popped_prio_ff, head_prio_ff;
   logic        [smpq_pkg::STATUS_W-1:0] status_ff;
   logic                                 not_empty_ff;
   logic        [smpq_pkg::FILL_W-1:0]   fill_ff;

   // keep: held entry not greater than the new priority, stays in place
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      logic                               keep_prev;
      logic        [smpq_pkg::TAG_W-1:0]  prev_tag, next_tag;
      logic signed [smpq_pkg::PRIO_W-1:0] prev_prio, next_prio;

      assign keep[i] = (OCC_W'(i) < occ_ff) && (prio_ff[i] <= in_prio_ff);

      if (i == 0) begin : g_first
         assign keep_prev = 1'b1;
         assign prev_tag  = in_tag_ff;
         assign prev_prio = in_prio_ff;
      end else begin : g_rest
         assign keep_prev = keep[i-1];
         assign prev_tag  = tag_ff[i-1];
         assign prev_prio = prio_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_tag  = tag_ff[i];
         assign next_prio = prio_ff[i];
      end else begin : g_inner
         assign next_tag  = tag_ff[i+1];
         assign next_prio = prio_ff[i+1];
      end

      always_comb begin
         tag_in[i]  = tag_ff[i];
         prio_in[i] = prio_ff[i];
         if (cmd.do_push) begin
            if (!keep[i]) begin
               if (keep_prev) begin
                  tag_in[i]  = in_tag_ff;
                  prio_in[i] = in_prio_ff;
               end else begin
                  tag_in[i]  = prev_tag;
                  prio_in[i] = prev_prio;
               end
            end
         end else if (cmd.do_pop) begin
            tag_in[i]  = next_tag;
            prio_in[i] = next_prio;
         end
      end

      always_ff @(posedge clock) begin
         tag_ff[i]  <= tag_in[i];
         prio_ff[i] <= prio_in[i];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.do_push) occ_in = occ_ff + OCC_W'(1);
      else if (cmd.do_pop) occ_in = occ_ff - OCC_W'(1);
   end

   assign stat.is_pop = (in_op_ff == smpq_pkg::OP_POP);
   assign stat.full   = (occ_ff == OCC_W'(DEPTH));
   assign stat.empty  = (occ_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_op_ff   <= req_op;
         in_tag_ff  <= req_task_tag;
         in_prio_ff <= req_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_rsp) begin
         popped_task_ff <= cmd.do_pop ? tag_ff[0]  : '0;
         popped_prio_ff <= cmd.do_pop ? prio_ff[0] : '0;
         status_ff      <= cmd.code;
         head_task_ff   <= (occ_in != '0) ? tag_in[0]  : '0;
         head_prio_ff   <= (occ_in != '0) ? prio_in[0] : '0;
         not_empty_ff   <= (occ_in != '0);
         fill_ff        <= smpq_pkg::FILL_W'(occ_in);
      end
   end

   assign rsp_popped_task = popped_task_ff;
   assign rsp_popped_prio = popped_prio_ff;
   assign rsp_status      = status_ff;
   assign rsp_head_task   = head_task_ff;
   assign rsp_head_prio   = head_prio_ff;
   assign rsp_not_empty   = not_empty_ff;
   assign rsp_fill        = fill_ff;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_min_priority_queue_unit. Every accepted req_
// word is run through a local model of the sorted queue, and every rsp_ word
// is compared field by field with the oldest prediction. Directed words cover
// empty pops, extreme and tied priorities and the full-queue drop. Random
// bursts of push-heavy, balanced and pop-heavy traffic follow under several
// idling patterns. One long output stall backs the queue up into its input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH       = smpq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_WORDS = 250;

   typedef struct {
      logic        [smpq_pkg::TAG_W-1:0]  popped_task;
      logic signed [smpq_pkg::PRIO_W-1:0] popped_prio;
      smpq_pkg::status_type               status;
      logic        [smpq_pkg::TAG_W-1:0]  head_task;
      logic signed [smpq_pkg::PRIO_W-1:0] head_prio;
      logic                               not_empty;
      logic        [smpq_pkg::FILL_W-1:0] fill;
   } queue_result_type;

   logic                                 clock        = 1'b0;
   logic                                 reset        = 1'b1;
   logic                                 req_valid    = 1'b0;
   logic                                 req_ready;
   logic                                 req_op       = smpq_pkg::OP_PUSH;
   logic        [smpq_pkg::TAG_W-1:0]    req_task_tag = '0;
   logic signed [smpq_pkg::PRIO_W-1:0]   req_prio     = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready    = 1'b0;
   logic        [smpq_pkg::TAG_W-1:0]    rsp_popped_task;
   logic signed [smpq_pkg::PRIO_W-1:0]   rsp_popped_prio;
   logic        [smpq_pkg::STATUS_W-1:0] rsp_status;
   logic        [smpq_pkg::TAG_W-1:0]    rsp_head_task;
   logic signed [smpq_pkg::PRIO_W-1:0]   rsp_head_prio;
   logic                                 rsp_not_empty;
   logic        [smpq_pkg::FILL_W-1:0]   rsp_fill;

   // sorted copy of the queue, head at index 0
   logic        [smpq_pkg::TAG_W-1:0]  held_tag  [DEPTH];
   logic signed [smpq_pkg::PRIO_W-1:0] held_prio [DEPTH];
   int                                 held_count = 0;
   queue_result_type                   expected_results[$];

   int error_count     = 0;
   int cycle_count     = 0;
   int checked_results = 0;
   int push_count      = 0;
   int pop_count       = 0;
   int full_drops      = 0;
   int empty_pops      = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   int hold_left       = 0;

   stable_min_priority_queue_unit #(.DEPTH(DEPTH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_task_tag    (req_task_tag),
      .req_prio        (req_prio),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_popped_task (rsp_popped_task),
      .rsp_popped_prio (rsp_popped_prio),
      .rsp_status      (rsp_status),
      .rsp_head_task   (rsp_head_task),
      .rsp_head_prio   (rsp_head_prio),
      .rsp_not_empty   (rsp_not_empty),
      .rsp_fill        (rsp_fill)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void apply_queue_op(input logic op,
                                          input logic [smpq_pkg::TAG_W-1:0] tag,
                                          input logic signed [smpq_pkg::PRIO_W-1:0] prio);
      queue_result_type r;
      int pos;
      int i;
      r.popped_task = '0;
      r.popped_prio = '0;
      r.status      = smpq_pkg::ST_OK;
      if (op == smpq_pkg::OP_PUSH) begin
         push_count++;
         if (held_count >= DEPTH) begin
            r.status = smpq_pkg::ST_FULL;
            full_drops++;
         end else begin
            // new entry goes behind every entry of equal or smaller priority
            pos = 0;
            while (pos < held_count && held_prio[pos] <= prio) pos++;
            for (i = held_count; i > pos; i--) begin
               held_tag[i]  = held_tag[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_tag[pos]  = tag;
            held_prio[pos] = prio;
            held_count++;
         end
      end else begin
         pop_count++;
         if (held_count == 0) begin
            r.status = smpq_pkg::ST_EMPTY;
            empty_pops++;
         end else begin
            r.popped_task = held_tag[0];
            r.popped_prio = held_prio[0];
            for (i = 1; i < held_count; i++) begin
               held_tag[i-1]  = held_tag[i];
               held_prio[i-1] = held_prio[i];
            end
            held_count--;
         end
      end
      r.not_empty = (held_count > 0);
      r.head_task = (held_count > 0) ? held_tag[0]  : '0;
      r.head_prio = (held_count > 0) ? held_prio[0] : '0;
      r.fill      = held_count[smpq_pkg::FILL_W-1:0];
      expected_results.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) apply_queue_op(req_op, req_task_tag, req_prio);
   end

   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("rsp word with no prediction pending");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("popped_task", want.popped_task, rsp_popped_task);
            check_field("popped_prio", want.popped_prio, rsp_popped_prio);
            check_field("status",      want.status,      rsp_status);
            check_field("head_task",   want.head_task,   rsp_head_task);
            check_field("head_prio",   want.head_prio,   rsp_head_prio);
            check_field("not_empty",   want.not_empty,   rsp_not_empty);
            check_field("fill",        want.fill,        rsp_fill);
            checked_results++;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input logic op, input logic [smpq_pkg::TAG_W-1:0] tag,
                            input logic signed [smpq_pkg::PRIO_W-1:0] prio);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_task_tag <= tag;
      req_prio     <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic signed [smpq_pkg::PRIO_W-1:0] pick_prio();
      logic signed [smpq_pkg::PRIO_W-1:0] p;
      case ($urandom_range(9))
         0, 1, 2, 3: p = smpq_pkg::PRIO_W'($urandom_range(6)) - smpq_pkg::PRIO_W'(3);
         4, 5, 6, 7: p = smpq_pkg::PRIO_W'($urandom);
         default: begin
            case ($urandom_range(3))
               0:       p = 16'sh8000;
               1:       p = 16'sh7FFF;
               2:       p = '0;
               default: p = -16'sd1;
            endcase
         end
      endcase
      return p;
   endfunction

   task automatic test_pop_on_empty();
      send_word(smpq_pkg::OP_POP, 16'hFFFF, 16'sh7FFF);
   endtask

   task automatic test_extremes_and_ties();
      send_word(smpq_pkg::OP_PUSH, 16'h0000, 16'sh7FFF);
      send_word(smpq_pkg::OP_PUSH, 16'hFFFF, 16'sh8000);
      send_word(smpq_pkg::OP_PUSH, 16'h0001, 16'sh0000);
      send_word(smpq_pkg::OP_PUSH, 16'h0002, 16'sh0000);
      send_word(smpq_pkg::OP_PUSH, 16'h0003, 16'sh0000);
      send_word(smpq_pkg::OP_PUSH, 16'h0004, -16'sd1);
      send_word(smpq_pkg::OP_PUSH, 16'h0005, 16'sh8000);
      repeat (4) send_word(smpq_pkg::OP_POP, 16'h5A5A, 16'sh2AAA);
   endtask

   task automatic test_push_on_full();
      int i;
      // three entries remain from the previous test
      for (i = 0; i < DEPTH - 3; i++)
         send_word(smpq_pkg::OP_PUSH, smpq_pkg::TAG_W'(16'h0100 + i), 16'sh7FFF);
      send_word(smpq_pkg::OP_PUSH, 16'hABCD, 16'sh8000);
   endtask

   task automatic test_output_stall();
      int i;
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = HOLD_CYCLES;
      for (i = 0; i < 24; i++) begin
         if ($urandom_range(99) < 60)
            send_word(smpq_pkg::OP_PUSH, smpq_pkg::TAG_W'($urandom), pick_prio());
         else
            send_word(smpq_pkg::OP_POP, smpq_pkg::TAG_W'($urandom),
                      smpq_pkg::PRIO_W'($urandom));
      end
   endtask

   task automatic test_random_traffic(input int n_words, input int send_idle,
                                      input int rsp_stall);
      int sent;
      int burst;
      int push_pct;
      int k;
      idle_pct  = send_idle;
      stall_pct = rsp_stall;
      sent      = 0;
      while (sent < n_words) begin
         burst = $urandom_range(40, 10);
         case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 20;
         endcase
         for (k = 0; k < burst && sent < n_words; k++) begin
            if ($urandom_range(99) < push_pct)
               send_word(smpq_pkg::OP_PUSH, smpq_pkg::TAG_W'($urandom), pick_prio());
            else
               send_word(smpq_pkg::OP_POP, smpq_pkg::TAG_W'($urandom),
                         smpq_pkg::PRIO_W'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_pop_on_empty();
      test_extremes_and_ties();
      test_push_on_full();
      test_random_traffic(PHASE_WORDS, 0, 0);
      test_random_traffic(PHASE_WORDS, 51, 0);
      test_output_stall();
      test_random_traffic(PHASE_WORDS, 0, 51);
      test_random_traffic(PHASE_WORDS, 24, 24);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d pushes (%0d dropped on full) and %0d pops (%0d on empty).",
               push_count, full_drops, pop_count, empty_pops);
      $display("Checked %0d rsp words over four idling mixes and a %0d-cycle output stall.",
               checked_results, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
